@@ hdl/table_interpolated_drive_current_macros.svh @@
// Assertion helpers shared by the drive-current modules.
`ifndef TABLE_INTERPOLATED_DRIVE_CURRENT_MACROS_SVH
`define TABLE_INTERPOLATED_DRIVE_CURRENT_MACROS_SVH

// Same-cycle implication under reset.
`define TIDC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tidc check failed");

// Next-cycle implication under reset.
`define TIDC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tidc check failed");

`endif

@@ hdl/tidc_pkg.sv @@
`timescale 1ns / 1ps

package tidc_pkg;

    localparam int POINTS     = 8;
    localparam int IDX_W      = $clog2(POINTS);
    localparam int NUM_TABLES = 4;
    localparam int TAB_W      = 2;
    localparam int ADDR_W     = TAB_W + IDX_W;
    localparam int DEPTH      = NUM_TABLES * POINTS;
    localparam int DATA_W     = 16;
    localparam int BOOST_W    = 9;
    localparam int TICK_MS    = 2;
    localparam int BOOST_CAP  = 500;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CNT_W      = $clog2(PROD_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;

    localparam logic [DATA_W-1:0]  STEP_TIME_RST    = 16'd100;
    localparam logic [BOOST_W-1:0] STEP_CURRENT_RST = 9'd10;
    localparam logic [DATA_W-1:0]  MAX_CURRENT_RST  = 16'd65535;

    typedef enum logic [TAB_W-1:0] {
        TAB_UP_ANG = 2'd0,
        TAB_UP_CUR = 2'd1,
        TAB_DN_ANG = 2'd2,
        TAB_DN_CUR = 2'd3
    } tab_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic {
        OP_DRIVE = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TIME    = 2'd0,
        CFG_STEP_CURRENT = 2'd1,
        CFG_MAX_CURRENT  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]  step_time;
        logic [BOOST_W-1:0] step_current;
        logic [DATA_W-1:0]  max_current;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic             rd_cur;
        logic [IDX_W-1:0] rd_idx;
        logic             ang_step;
        logic             ang_found;
        logic             cap_c0;
        logic             cap_c1;
        logic             cap_base;
        logic             mul;
        logic             div_step;
        logic             quot;
        logic             commit;
    } cmd_t;

    typedef struct packed {
        logic move;
        logic lt;
    } stat_t;

endpackage

@@ hdl/tidc_in_if.sv @@
`timescale 1ns / 1ps

interface tidc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [1:0]                   direction;
    logic [tidc_pkg::DATA_W-1:0]  error_centideg;
    logic [tidc_pkg::TAB_W-1:0]   table_select;
    logic [tidc_pkg::IDX_W-1:0]   table_index;
    logic [tidc_pkg::DATA_W-1:0]  table_value;

    modport source (
        output valid, operation, direction, error_centideg,
        output table_select, table_index, table_value,
        input  ready
    );

    modport sink (
        input  valid, operation, direction, error_centideg,
        input  table_select, table_index, table_value,
        output ready
    );
endinterface

@@ hdl/tidc_out_if.sv @@
`timescale 1ns / 1ps

interface tidc_out_if;
    logic                          valid;
    logic                          ready;
    logic [tidc_pkg::DATA_W-1:0]   up_drive;
    logic [tidc_pkg::DATA_W-1:0]   down_drive;
    logic [tidc_pkg::BOOST_W-1:0]  up_boost;
    logic [tidc_pkg::BOOST_W-1:0]  down_boost;

    modport source (
        output valid, up_drive, down_drive, up_boost, down_boost,
        input  ready
    );

    modport sink (
        input  valid, up_drive, down_drive, up_boost, down_boost,
        output ready
    );
endinterface

@@ hdl/tidc_cfg.sv @@
`timescale 1ns / 1ps

module tidc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tidc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tidc_pkg::CFG_W-1:0]       cfg_wdata,
    output tidc_pkg::cfg_t                   cfg
);

    tidc_pkg::cfg_t cfg_reg;
    tidc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tidc_pkg::CFG_STEP_TIME:
                begin
                    cfg_next.step_time = cfg_wdata[tidc_pkg::DATA_W-1:0];
                end
                tidc_pkg::CFG_STEP_CURRENT:
                begin
                    cfg_next.step_current = cfg_wdata[tidc_pkg::BOOST_W-1:0];
                end
                tidc_pkg::CFG_MAX_CURRENT:
                begin
                    cfg_next.max_current = cfg_wdata[tidc_pkg::DATA_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_time    <= tidc_pkg::STEP_TIME_RST;
            cfg_reg.step_current <= tidc_pkg::STEP_CURRENT_RST;
            cfg_reg.max_current  <= tidc_pkg::MAX_CURRENT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/tidc_ctrl.sv @@
`timescale 1ns / 1ps
`include "table_interpolated_drive_current_macros.svh"

module tidc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  tidc_pkg::stat_t stat,
    output tidc_pkg::cmd_t  cmd
);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_DECODE   = 13'b0000000000010,
        ST_RD_ANG   = 13'b0000000000100,
        ST_CMP_ANG  = 13'b0000000001000,
        ST_RD_C0    = 13'b0000000010000,
        ST_RD_C1    = 13'b0000000100000,
        ST_CAP_C1   = 13'b0000001000000,
        ST_MUL      = 13'b0000010000000,
        ST_DIV      = 13'b0000100000000,
        ST_QUOT     = 13'b0001000000000,
        ST_RD_BASE  = 13'b0010000000000,
        ST_CAP_BASE = 13'b0100000000000,
        ST_COMMIT   = 13'b1000000000000
    } state_t;

    localparam logic [tidc_pkg::IDX_W-1:0] IDX_LAST =
        tidc_pkg::IDX_W'(tidc_pkg::POINTS - 1);
    localparam logic [tidc_pkg::CNT_W-1:0] CNT_LAST =
        tidc_pkg::CNT_W'(tidc_pkg::PROD_W - 1);

    state_t                       state_reg;
    state_t                       state_next;
    logic [tidc_pkg::IDX_W-1:0]   idx_reg;
    logic [tidc_pkg::IDX_W-1:0]   idx_next;
    logic [tidc_pkg::CNT_W-1:0]   cnt_reg;
    logic [tidc_pkg::CNT_W-1:0]   cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.rd_idx     = idx_reg;
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                idx_next   = '0;
                state_next = stat.move ? ST_RD_ANG : ST_COMMIT;
            end
            ST_RD_ANG:
            begin
                state_next = ST_CMP_ANG;
            end
            ST_CMP_ANG:
            begin
                if (stat.lt)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = ST_RD_BASE;
                    end
                    else
                    begin
                        cmd.ang_found = 1'b1;
                        state_next    = ST_RD_C0;
                    end
                end
                else
                begin
                    cmd.ang_step = 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_RD_BASE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD_ANG;
                    end
                end
            end
            ST_RD_C0:
            begin
                cmd.rd_cur = 1'b1;
                cmd.rd_idx = idx_reg - 1'b1;
                state_next = ST_RD_C1;
            end
            ST_RD_C1:
            begin
                cmd.rd_cur = 1'b1;
                cmd.cap_c0 = 1'b1;
                state_next = ST_CAP_C1;
            end
            ST_CAP_C1:
            begin
                cmd.cap_c1 = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_RD_BASE:
            begin
                cmd.rd_cur = 1'b1;
                state_next = ST_CAP_BASE;
            end
            ST_CAP_BASE:
            begin
                cmd.cap_base = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TIDC_ASSERT_NXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_reg == ST_DECODE)
    `TIDC_ASSERT_NXT(a_div_done, clk, rst_n, state_reg == ST_DIV && cnt_reg == CNT_LAST, state_reg == ST_QUOT)
    `TIDC_ASSERT_NXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_reg && state_reg == ST_IDLE)

endmodule

@@ hdl/tidc_dp.sv @@
`timescale 1ns / 1ps
`include "table_interpolated_drive_current_macros.svh"

module tidc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tidc_pkg::cmd_t                  cmd,
    output tidc_pkg::stat_t                 stat,
    input  tidc_pkg::cfg_t                  cfg,
    input  logic                            operation,
    input  logic [1:0]                      direction,
    input  logic [tidc_pkg::DATA_W-1:0]     error_centideg,
    input  logic [tidc_pkg::TAB_W-1:0]      table_select,
    input  logic [tidc_pkg::IDX_W-1:0]      table_index,
    input  logic [tidc_pkg::DATA_W-1:0]     table_value,
    output logic [tidc_pkg::DATA_W-1:0]     up_drive,
    output logic [tidc_pkg::DATA_W-1:0]     down_drive,
    output logic [tidc_pkg::BOOST_W-1:0]    up_boost,
    output logic [tidc_pkg::BOOST_W-1:0]    down_boost
);

    localparam int DW = tidc_pkg::DATA_W;
    localparam int BW = tidc_pkg::BOOST_W;
    localparam int AW = tidc_pkg::ADDR_W;
    localparam int PW = tidc_pkg::PROD_W;
    localparam int IW = tidc_pkg::IDX_W;

    function automatic logic [BW-1:0] bump_boost(input logic [BW-1:0] boost,
                                                 input logic [BW-1:0] step);
        logic [BW:0] sum;
        sum = {1'b0, boost} + {1'b0, step};
        if (sum >= (BW+1)'(tidc_pkg::BOOST_CAP))
        begin
            return BW'(tidc_pkg::BOOST_CAP);
        end
        return sum[BW-1:0];
    endfunction

    function automatic logic [DW-1:0] saturate(input logic [DW-1:0] base,
                                               input logic [BW-1:0] boost,
                                               input logic [DW-1:0] limit);
        logic [DW:0] sum;
        sum = {1'b0, base} + (DW+1)'(boost);
        if (sum >= {1'b0, limit})
        begin
            return limit;
        end
        return sum[DW-1:0];
    endfunction

    logic [DW-1:0]  mem [tidc_pkg::DEPTH];

    logic           op_reg;
    logic [1:0]     dir_reg;
    logic [DW-1:0]  err_reg;
    logic [tidc_pkg::TAB_W-1:0] sel_reg;
    logic [IW-1:0]  idx_reg;
    logic [DW-1:0]  val_reg;

    logic [DW-1:0]  rd_data_reg;
    logic [DW-1:0]  ang_lo_reg;
    logic [DW-1:0]  ang_hi_reg;
    logic [DW-1:0]  c0_reg;
    logic [DW-1:0]  c1_reg;
    logic [DW-1:0]  base_reg;
    logic [PW-1:0]  dvd_reg;
    logic [DW-1:0]  rem_reg;
    logic           neg_reg;

    logic [DW-1:0]  up_drive_reg;
    logic [DW-1:0]  up_drive_next;
    logic [DW-1:0]  down_drive_reg;
    logic [DW-1:0]  down_drive_next;
    logic [BW-1:0]  up_boost_reg;
    logic [BW-1:0]  up_boost_next;
    logic [BW-1:0]  down_boost_reg;
    logic [BW-1:0]  down_boost_next;
    logic [DW-1:0]  up_timer_reg;
    logic [DW-1:0]  up_timer_next;
    logic [DW-1:0]  down_timer_reg;
    logic [DW-1:0]  down_timer_next;

    tidc_pkg::tab_t rd_tab;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic [DW-1:0]  dc_mag;
    logic [DW-1:0]  dx;
    logic [DW-1:0]  span;
    logic [PW-1:0]  prod;
    logic [DW:0]    rem_shift;
    logic [DW:0]    rem_sub;
    logic           rem_ge;
    logic [DW-1:0]  quot;
    logic [DW-1:0]  up_timer_inc;
    logic [DW-1:0]  down_timer_inc;

    always_comb
    begin
        if (dir_reg == tidc_pkg::DIR_DOWN)
        begin
            rd_tab = cmd.rd_cur ? tidc_pkg::TAB_DN_CUR : tidc_pkg::TAB_DN_ANG;
        end
        else
        begin
            rd_tab = cmd.rd_cur ? tidc_pkg::TAB_UP_CUR : tidc_pkg::TAB_UP_ANG;
        end
    end

    assign rd_addr = AW'(rd_tab) * AW'(tidc_pkg::POINTS) + AW'(cmd.rd_idx);
    assign wr_addr = AW'(sel_reg) * AW'(tidc_pkg::POINTS) + AW'(idx_reg);
    assign wr_en   = cmd.commit && (op_reg == tidc_pkg::OP_WRITE)
                     && ({1'b0, idx_reg} < (IW+1)'(tidc_pkg::POINTS));

    assign stat.lt   = err_reg < rd_data_reg;
    assign stat.move = (op_reg == tidc_pkg::OP_DRIVE)
                       && (dir_reg == tidc_pkg::DIR_UP || dir_reg == tidc_pkg::DIR_DOWN);

    assign dc_mag    = (c1_reg >= c0_reg) ? (c1_reg - c0_reg) : (c0_reg - c1_reg);
    assign dx        = err_reg - ang_lo_reg;
    assign span      = ang_hi_reg - ang_lo_reg;
    assign prod      = PW'(dc_mag) * PW'(dx);
    assign rem_shift = {rem_reg, dvd_reg[PW-1]};
    assign rem_ge    = rem_shift >= {1'b0, span};
    assign rem_sub   = rem_shift - {1'b0, span};
    assign quot      = dvd_reg[DW-1:0];

    assign up_timer_inc   = up_timer_reg + DW'(tidc_pkg::TICK_MS);
    assign down_timer_inc = down_timer_reg + DW'(tidc_pkg::TICK_MS);

    always_comb
    begin
        up_drive_next   = up_drive_reg;
        down_drive_next = down_drive_reg;
        up_boost_next   = up_boost_reg;
        down_boost_next = down_boost_reg;
        up_timer_next   = up_timer_reg;
        down_timer_next = down_timer_reg;
        if (cmd.commit && op_reg == tidc_pkg::OP_DRIVE)
        begin
            case (dir_reg)
                tidc_pkg::DIR_UP:
                begin
                    down_boost_next = '0;
                    down_timer_next = '0;
                    if (up_timer_inc >= cfg.step_time)
                    begin
                        up_timer_next = '0;
                        up_boost_next = bump_boost(up_boost_reg, cfg.step_current);
                    end
                    else
                    begin
                        up_timer_next = up_timer_inc;
                    end
                    up_drive_next = saturate(base_reg, up_boost_next, cfg.max_current);
                end
                tidc_pkg::DIR_DOWN:
                begin
                    up_boost_next = '0;
                    up_timer_next = '0;
                    if (down_timer_inc > cfg.step_time)
                    begin
                        down_timer_next = '0;
                        down_boost_next = bump_boost(down_boost_reg, cfg.step_current);
                    end
                    else
                    begin
                        down_timer_next = down_timer_inc;
                    end
                    down_drive_next = saturate(base_reg, down_boost_next, cfg.max_current);
                end
                default:
                begin
                    up_drive_next   = '0;
                    down_drive_next = '0;
                    up_boost_next   = '0;
                    down_boost_next = '0;
                    up_timer_next   = '0;
                    down_timer_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            dir_reg <= direction;
            err_reg <= error_centideg;
            sel_reg <= table_select;
            idx_reg <= table_index;
            val_reg <= table_value;
        end
        if (cmd.ang_step)
        begin
            ang_lo_reg <= rd_data_reg;
        end
        if (cmd.ang_found)
        begin
            ang_hi_reg <= rd_data_reg;
        end
        if (cmd.cap_c0)
        begin
            c0_reg <= rd_data_reg;
        end
        if (cmd.cap_c1)
        begin
            c1_reg <= rd_data_reg;
        end
        if (cmd.cap_base)
        begin
            base_reg <= rd_data_reg;
        end
        else if (cmd.quot)
        begin
            base_reg <= neg_reg ? (c0_reg - quot) : (c0_reg + quot);
        end
        if (cmd.mul)
        begin
            dvd_reg <= prod;
            rem_reg <= '0;
            neg_reg <= c1_reg < c0_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
            dvd_reg <= {dvd_reg[PW-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_drive_reg   <= '0;
            down_drive_reg <= '0;
            up_boost_reg   <= '0;
            down_boost_reg <= '0;
            up_timer_reg   <= '0;
            down_timer_reg <= '0;
        end
        else
        begin
            up_drive_reg   <= up_drive_next;
            down_drive_reg <= down_drive_next;
            up_boost_reg   <= up_boost_next;
            down_boost_reg <= down_boost_next;
            up_timer_reg   <= up_timer_next;
            down_timer_reg <= down_timer_next;
        end
    end

    assign up_drive   = up_drive_reg;
    assign down_drive = down_drive_reg;
    assign up_boost   = up_boost_reg;
    assign down_boost = down_boost_reg;

    `TIDC_ASSERT_IMP(a_boost_cap, clk, rst_n, 1'b1, up_boost_reg <= BW'(tidc_pkg::BOOST_CAP) && down_boost_reg <= BW'(tidc_pkg::BOOST_CAP))
    `TIDC_ASSERT_IMP(a_one_boost, clk, rst_n, 1'b1, up_boost_reg == '0 || down_boost_reg == '0)
    `TIDC_ASSERT_IMP(a_rem_below_span, clk, rst_n, cmd.div_step, rem_reg < span)
    `TIDC_ASSERT_IMP(a_quot_fits, clk, rst_n, cmd.quot, dvd_reg[PW-1:DW] == '0)

endmodule

@@ hdl/table_interpolated_drive_current.sv @@
`timescale 1ns / 1ps
// From input transfer to result: a table write or stop step goes from decode to commit;
// otherwise the angle table is scanned point by point through the single store read port,
// then the base current is read when the error lies below the first point or past the last,
// or else the bracketing currents are read and interpolated through a bit-serial divider.
// One item at a time: the next transfer is taken the cycle after the result loads.
// Reset clears drives, boosts, stall timers; config to 100, 10, 65535; store undefined.

module table_interpolated_drive_current (
    input  logic                            clk,
    input  logic                            rst_n,
    tidc_in_if.sink                         drv_in,
    tidc_out_if.source                      drv_out,
    input  logic                            cfg_we,
    input  logic [tidc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tidc_pkg::CFG_W-1:0]      cfg_wdata
);

    tidc_pkg::cfg_t  cfg;
    tidc_pkg::cmd_t  cmd;
    tidc_pkg::stat_t stat;

    tidc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (drv_in.valid),
        .in_ready  (drv_in.ready),
        .out_valid (drv_out.valid),
        .out_ready (drv_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tidc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg),
        .operation      (drv_in.operation),
        .direction      (drv_in.direction),
        .error_centideg (drv_in.error_centideg),
        .table_select   (drv_in.table_select),
        .table_index    (drv_in.table_index),
        .table_value    (drv_in.table_value),
        .up_drive       (drv_out.up_drive),
        .down_drive     (drv_out.down_drive),
        .up_boost       (drv_out.up_boost),
        .down_boost     (drv_out.down_boost)
    );

endmodule
